// ----- rtl/core/efw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// efw_pkg
// Shared types, sizes and codes for the event flag waiter unit.
// ----------------------------------------------------------------------------
package efw_pkg;

    // table sizing
    localparam int MAX_WAITERS = 8;
    localparam int MAX_TASKS   = 16;
    localparam int SLOT_W      = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CNT_W       = $clog2(MAX_WAITERS + 1);

    // field widths
    localparam int FLAG_W   = 32;
    localparam int TASK_W   = 4;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int ENTRY_W  = FLAG_W + TASK_W;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WAIT  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_WOKEN     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_DONE      = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_IMMEDIATE = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_BLOCKED   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_ZERO      = 3'd5;

    // scan sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MOVE,
        ST_FINAL
    } t_state;

    // fold a caller index into the task range
    function automatic logic [TASK_W-1:0] wrap_task(input logic [TASK_W-1:0] t);
        logic [31:0] wide;
        wide = 32'(t) % MAX_TASKS;
        return wide[TASK_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/efw_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// efw_ram
// Generic simple dual port RAM: one write port, one read port with
// registered read data held while the read enable is low.
// ----------------------------------------------------------------------------
module efw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/event_flag_waiter_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// event_flag_waiter_unit
// Event flag word with a compact table of wait-all waiters and auto-clear.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_valid / o_stall with i_kind, i_mask, i_caller_task.
//   Results leave on o_valid / i_stall; every request ends with one result
//   that has o_last set, and a set request first gives one woken result per
//   released task in scan order (highest live slot downward).
//   Clear, wait and ignored requests can follow back to back while the
//   output register drains.
//   A set request walks the table in the waiter RAM, reading one slot per
//   cycle except while a wake waits on a stalled output, and each wake
//   adds a move step that copies the tail entry into the freed slot
//   through the single RAM write port.
//   Reset clears the flag word and the live count; the waiter RAM needs no
//   clearing pass since only live slots are ever read.
//   When the receiver stalls, the pending result holds in the output register
//   and the scan stops at its next result until it is taken; no request is accepted
//   until the previous one has produced all of its results.
// ----------------------------------------------------------------------------
module event_flag_waiter_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [efw_pkg::KIND_W-1:0]     i_kind,
    input  wire logic [efw_pkg::FLAG_W-1:0]     i_mask,
    input  wire logic [efw_pkg::TASK_W-1:0]     i_caller_task,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic      [efw_pkg::STATUS_W-1:0]   o_status,
    output logic      [efw_pkg::TASK_W-1:0]     o_woken_task,
    output logic      [efw_pkg::FLAG_W-1:0]     o_flags_now,
    output logic                                o_last
);

    localparam int SLOT_W  = efw_pkg::SLOT_W;
    localparam int CNT_W   = efw_pkg::CNT_W;
    localparam int FLAG_W  = efw_pkg::FLAG_W;
    localparam int TASK_W  = efw_pkg::TASK_W;
    localparam int ENTRY_W = efw_pkg::ENTRY_W;
    localparam int STAT_W  = efw_pkg::STATUS_W;

    efw_pkg::t_state r_state, n_state;

    logic [FLAG_W-1:0] r_flags, n_flags;
    logic [CNT_W-1:0]  r_live, n_live;
    logic [SLOT_W-1:0] r_slot, n_slot;

    logic              r_o_valid, n_o_valid;
    logic [STAT_W-1:0] r_o_status, n_o_status;
    logic [TASK_W-1:0] r_o_task, n_o_task;
    logic [FLAG_W-1:0] r_o_flags, n_o_flags;
    logic              r_o_last, n_o_last;
    logic              emit;

    logic               ram_we, ram_re;
    logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    logic               out_free, accept, hit;
    logic [FLAG_W-1:0]  rd_mask;
    logic [TASK_W-1:0]  rd_task;
    logic [CNT_W-1:0]   live_dec;
    logic [SLOT_W-1:0]  tail_slot, slot_dec;

    // waiter table: mask and task per slot
    efw_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (efw_pkg::MAX_WAITERS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // handshake and slot helpers
    assign out_free  = !r_o_valid || !i_stall;
    assign o_stall   = !((r_state == efw_pkg::ST_IDLE) && out_free);
    assign accept    = i_valid && !o_stall;
    assign rd_mask   = ram_rdata[ENTRY_W-1:TASK_W];
    assign rd_task   = ram_rdata[TASK_W-1:0];
    assign hit       = (r_flags & rd_mask) == rd_mask;
    assign live_dec  = r_live - CNT_W'(1);
    assign tail_slot = live_dec[SLOT_W-1:0];
    assign slot_dec  = r_slot - SLOT_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            efw_pkg::ST_IDLE: begin
                if (accept && (i_kind == efw_pkg::KIND_SET) && (i_mask != '0)) begin
                    n_state = (r_live == '0) ? efw_pkg::ST_FINAL : efw_pkg::ST_CHECK;
                end
            end
            efw_pkg::ST_CHECK: begin
                if (hit) begin
                    if (out_free) begin
                        n_state = efw_pkg::ST_MOVE;
                    end
                end else if (r_slot == '0) begin
                    n_state = efw_pkg::ST_FINAL;
                end
            end
            efw_pkg::ST_MOVE: begin
                n_state = (r_slot == '0) ? efw_pkg::ST_FINAL : efw_pkg::ST_CHECK;
            end
            efw_pkg::ST_FINAL: begin
                if (out_free) begin
                    n_state = efw_pkg::ST_IDLE;
                end
            end
            default: n_state = efw_pkg::ST_IDLE;
        endcase
    end

    // datapath, table access and result generation
    always_comb begin
        n_flags    = r_flags;
        n_live     = r_live;
        n_slot     = r_slot;
        ram_we     = 1'b0;
        ram_waddr  = r_slot;
        ram_wdata  = ram_rdata;
        ram_re     = 1'b0;
        ram_raddr  = r_slot;
        emit       = 1'b0;
        n_o_status = efw_pkg::STAT_DONE;
        n_o_task   = '0;
        n_o_last   = 1'b1;
        n_o_flags  = r_flags;

        unique case (r_state)
            efw_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (i_kind)
                        efw_pkg::KIND_SET: begin
                            if (i_mask == '0) begin
                                emit       = 1'b1;
                                n_o_status = efw_pkg::STAT_ZERO;
                            end else begin
                                // start the walk at the highest live slot
                                n_flags   = r_flags | i_mask;
                                n_slot    = tail_slot;
                                ram_re    = (r_live != '0);
                                ram_raddr = tail_slot;
                            end
                        end
                        efw_pkg::KIND_CLEAR: begin
                            n_flags   = r_flags & ~i_mask;
                            n_o_flags = r_flags & ~i_mask;
                            emit      = 1'b1;
                        end
                        efw_pkg::KIND_WAIT: begin
                            emit = 1'b1;
                            if (i_mask == '0) begin
                                n_o_status = efw_pkg::STAT_ZERO;
                            end else if ((r_flags & i_mask) == i_mask) begin
                                n_flags    = r_flags & ~i_mask;
                                n_o_flags  = r_flags & ~i_mask;
                                n_o_status = efw_pkg::STAT_IMMEDIATE;
                            end else if (r_live >= CNT_W'(efw_pkg::MAX_WAITERS)) begin
                                n_o_status = efw_pkg::STAT_FULL;
                            end else begin
                                // append the waiter at the end of the table
                                ram_we     = 1'b1;
                                ram_waddr  = r_live[SLOT_W-1:0];
                                ram_wdata  = {i_mask, efw_pkg::wrap_task(i_caller_task)};
                                n_live     = r_live + CNT_W'(1);
                                n_o_status = efw_pkg::STAT_BLOCKED;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            efw_pkg::ST_CHECK: begin
                if (hit) begin
                    // wake the waiter and fetch the tail entry to refill its slot
                    if (out_free) begin
                        emit       = 1'b1;
                        n_o_status = efw_pkg::STAT_WOKEN;
                        n_o_task   = rd_task;
                        n_o_last   = 1'b0;
                        n_o_flags  = r_flags & ~rd_mask;
                        n_flags    = r_flags & ~rd_mask;
                        n_live     = live_dec;
                        ram_re     = 1'b1;
                        ram_raddr  = tail_slot;
                    end
                end else if (r_slot != '0) begin
                    n_slot    = slot_dec;
                    ram_re    = 1'b1;
                    ram_raddr = slot_dec;
                end
            end
            efw_pkg::ST_MOVE: begin
                // tail entry into the freed slot, next slot read in parallel
                ram_we    = 1'b1;
                ram_waddr = r_slot;
                ram_wdata = ram_rdata;
                if (r_slot != '0) begin
                    n_slot    = slot_dec;
                    ram_re    = 1'b1;
                    ram_raddr = slot_dec;
                end
            end
            efw_pkg::ST_FINAL: begin
                if (out_free) begin
                    emit = 1'b1;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // output register valid
    assign n_o_valid = emit || (r_o_valid && i_stall);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= efw_pkg::ST_IDLE;
            r_flags   <= '0;
            r_live    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_flags   <= n_flags;
            r_live    <= n_live;
            r_o_valid <= n_o_valid;
        end
    end

    // scan pointer and result payload
    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        if (emit) begin
            r_o_status <= n_o_status;
            r_o_task   <= n_o_task;
            r_o_flags  <= n_o_flags;
            r_o_last   <= n_o_last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_woken_task = r_o_task;
    assign o_flags_now  = r_o_flags;
    assign o_last       = r_o_last;

    // live count stays within the table
    a_live_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live <= CNT_W'(efw_pkg::MAX_WAITERS))
        else $error("live waiter count beyond table size");

    // a wake shrinks the table by exactly one entry
    a_wake_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == efw_pkg::ST_CHECK && hit && out_free)
        |=> (r_live == $past(live_dec)) && (r_state == efw_pkg::ST_MOVE))
        else $error("wake did not remove one waiter");

    // only wake results are not the final one
    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_last) |-> (r_o_status == efw_pkg::STAT_WOKEN))
        else $error("non-final result with a status other than woken");

    // table never read and written at the same slot in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("waiter table read and write collide");

endmodule
`default_nettype wire
